// File: design/chained_hash_table_core_defines.svh
// Assertion macros shared by the hash table core.
// No dependencies.
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH
// implication checked on every clock edge, off during reset
`define CHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: design/cht_pkg.sv
// Shared types and codes for the chained hash table.
// No dependencies.
`default_nettype none
package cht_pkg;
    localparam int OP_W  = 2;
    localparam int KEY_W = 31;
    localparam int SEL_W = 7;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd3;

    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [ST_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_LISTED   = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_CNT_RD, S_CNT_WAIT, S_DISPATCH,
        S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR,
        S_LIST_RD, S_LIST_OUT, S_RESP
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;       // capture request
        logic       hash_step;  // one reduction step of key mod buckets
        logic       cnt_rd;     // read chain count
        logic       cnt_wr;     // write chain count
        logic       cnt_inc;    // write count+1 (else count-1)
        logic       key_rd;     // read slot at idx
        logic       key_rd_next;// read slot at idx+1
        logic       key_wr_new; // write request key at count
        logic       key_wr_shift; // write shifted key at idx
        logic       idx_clr;
        logic       idx_inc;
        logic       out_load;   // present a result
        logic [ST_W-1:0] out_status;
        logic       out_listed; // key_out from slot data
        logic       out_last_auto;
    } cht_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic hash_done;
        logic sel_bad;
        logic cnt_zero;
        logic cnt_full;
        logic idx_at_end;   // idx == count
        logic idx_at_tail;  // idx+1 == count
        logic key_match;
    } cht_sts_t;
endpackage
`default_nettype wire

// File: design/chained_hash_table_core.sv
// Top level of the chained hash table: controller plus datapath.
// Depends on cht_pkg, cht_ctrl, cht_dp and the assertion macro header.
//
//  channel | signals                        | direction
//  input   | in_valid/in_ready, op,key,bucket | request in
//  output  | out_valid/out_ready, status,key_out,last | results out
//
// Each request reduces the key modulo BUCKETS (reciprocal multiply, then multiply and
// subtract) and reads the chain count; an insert then writes its key and count.
// Search/delete walk the chain slot by slot; a delete then shifts the later slots down.
// Display emits one result per stored key, read through the single chain memory port.
// Reset clears the controller, result valid and the per-bucket count valid bits.
// A stalled result holds the walk; the next request is taken once the last result is loaded.
`default_nettype none
`include "chained_hash_table_core_defines.svh"
module chained_hash_table_core
    import cht_pkg::*;
#(
    parameter int BUCKETS     = 101,
    parameter int CHAIN_DEPTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [SEL_W-1:0]  bucket,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ST_W-1:0]        status,
    output logic [KEY_W-1:0]       key_out,
    output logic                   last
);
    cht_cmd_t cmd;
    cht_sts_t sts;
    logic     out_busy;

    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_busy  (out_busy),
        .sts       (sts),
        .cmd       (cmd)
    );

    cht_dp #(.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .key       (key),
        .bucket    (bucket),
        .out_busy  (out_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .key_out   (key_out),
        .last      (last)
    );

    // a result never overwrites one still waiting
    `CHT_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_busy, "result overwritten")
    // a request is never taken twice: in_ready drops once one is accepted
    `CHT_ASSERT_NEXT(a_load_busy, in_valid && in_ready, !in_ready, "request taken twice")
    // memory is never written and result loaded in the same cycle
    `CHT_ASSERT_IMP(a_wr_out, cmd.key_wr_new || cmd.key_wr_shift, !cmd.out_load,
                    "write during result load")
endmodule
`default_nettype wire

// File: design/cht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 808
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: design/cht_ctrl.sv
// Controller state machine for the chained hash table.
// Depends on cht_pkg.
`default_nettype none
module cht_ctrl
    import cht_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     out_ready,
    input  wire logic     out_busy,
    input  wire cht_sts_t sts,
    output cht_cmd_t      cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_HASH;
            S_HASH:     if (sts.hash_done) state_next = S_CNT_RD;
            S_CNT_RD:   state_next = S_CNT_WAIT;
            S_CNT_WAIT: state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_INSERT:  state_next = S_RESP;
                    OP_DISPLAY: state_next = (sts.sel_bad || sts.cnt_zero) ? S_RESP
                                                                           : S_LIST_RD;
                    default:    state_next = S_SCAN_RD;
                endcase
            end
            S_SCAN_RD:  state_next = sts.idx_at_end ? S_RESP : S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (!sts.key_match)
                    state_next = S_SCAN_RD;
                else if (sts.op == OP_DELETE)
                    state_next = S_SHIFT_RD;
                else
                    state_next = S_RESP;
            end
            S_SHIFT_RD: state_next = sts.idx_at_tail ? S_RESP : S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_LIST_RD:  if (!out_busy) state_next = S_LIST_OUT;
            S_LIST_OUT: state_next = sts.idx_at_tail ? S_IDLE : S_LIST_RD;
            S_RESP:     if (!out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_HASH:     cmd.hash_step = 1'b1;
            S_CNT_RD:   cmd.cnt_rd = 1'b1;
            S_CNT_WAIT: cmd.idx_clr = 1'b1;
            S_DISPATCH:
            begin
                if (sts.op == OP_INSERT)
                begin
                    if (sts.cnt_full)
                        cmd.out_status = ST_FULL;
                    else
                    begin
                        cmd.out_status = ST_INSERTED;
                        cmd.key_wr_new = 1'b1;
                        cmd.cnt_wr = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                end
                else
                    cmd.out_status = ST_EMPTY;
            end
            S_SCAN_RD:
            begin
                cmd.key_rd = 1'b1;
                cmd.out_status = ST_ABSENT;
            end
            S_SCAN_CHK:
            begin
                cmd.out_status = ST_FOUND;
                if (!sts.key_match)
                    cmd.idx_inc = 1'b1;
                else if (sts.op == OP_DELETE)
                begin
                    cmd.cnt_wr = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.out_status = ST_FOUND;
                cmd.key_rd_next = 1'b1;
            end
            S_SHIFT_WR:
            begin
                cmd.out_status = ST_FOUND;
                cmd.key_wr_shift = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_LIST_RD:  cmd.key_rd = !out_busy;
            S_LIST_OUT:
            begin
                cmd.out_load = 1'b1;
                cmd.out_status = ST_LISTED;
                cmd.out_listed = 1'b1;
                cmd.out_last_auto = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_RESP:     cmd.out_load = !out_busy;
            default:    ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = out_ready;
endmodule
`default_nettype wire

// File: design/cht_dp.sv
// Datapath: request registers, key reduction, count memory, chain memory, result register.
// Depends on cht_pkg and cht_ram.
`default_nettype none
module cht_dp
    import cht_pkg::*;
#(
    parameter int BUCKETS     = 101,
    parameter int CHAIN_DEPTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cht_cmd_t          cmd,
    output cht_sts_t               sts,
    input  wire logic [OP_W-1:0]   op,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [SEL_W-1:0]  bucket,
    output logic                   out_busy,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ST_W-1:0]        status,
    output logic [KEY_W-1:0]       key_out,
    output logic                   last
);
    localparam int BW     = $clog2(BUCKETS);
    localparam int DW     = $clog2(CHAIN_DEPTH + 1);
    localparam int SLOTS  = BUCKETS * CHAIN_DEPTH;
    localparam int AW     = $clog2(SLOTS);
    localparam int QW     = KEY_W - BW + 1;
    localparam int PW     = 2 * KEY_W + 1;
    localparam int HSTEPS = 2;
    // ceil(2^(KEY_W+BW) / BUCKETS): the shifted product is the exact quotient for any key
    localparam longint unsigned RECIP_L =
        ((64'd1 << (KEY_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [KEY_W:0] RECIP = RECIP_L[KEY_W:0];

    // request registers
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [SEL_W-1:0] sel_reg;
    logic [QW-1:0]    quot_reg;
    logic [BW-1:0]    rem_reg;
    logic [1:0]       hcnt_reg;
    logic [BW-1:0]    bkt_reg;
    logic [DW-1:0]    cnt_reg, idx_reg;

    // count memory, valid bits stand in for reset of the table
    logic [BUCKETS-1:0] cnt_vld_reg;
    logic [BW-1:0]      bkt_sel, cnt_addr;
    logic [DW-1:0]      cnt_wdata, cnt_rdata;

    // key mod BUCKETS: 31x32 reciprocal multiply, then multiply back and subtract
    logic [PW-1:0]    prod;
    logic [KEY_W-1:0] qb, rem_full;

    always_comb
    begin
        prod     = PW'(key_reg) * PW'(RECIP);
        qb       = KEY_W'(quot_reg) * KEY_W'(BUCKETS);
        rem_full = key_reg - qb;
    end

    logic use_sel;
    logic sel_ok;
    assign use_sel = (op_reg == OP_DISPLAY);
    assign sel_ok  = (32'(sel_reg) < 32'(BUCKETS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg    <= '0;
            cnt_vld_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                hcnt_reg <= '0;
            else if (cmd.hash_step && hcnt_reg != 2'(HSTEPS))
                hcnt_reg <= hcnt_reg + 1'b1;
            if (cmd.cnt_wr)
                cnt_vld_reg[bkt_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= key;
            sel_reg <= bucket;
        end
        else if (cmd.hash_step && hcnt_reg != 2'(HSTEPS))
        begin
            if (hcnt_reg == '0)
                quot_reg <= prod[PW-1 -: QW];
            else
                rem_reg <= rem_full[BW-1:0];
        end
        if (cmd.cnt_rd)
            bkt_reg <= bkt_sel;
        if (cmd.idx_clr)
            cnt_reg <= cnt_vld_reg[bkt_reg] ? cnt_rdata : '0;
        if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
    end

    // count memory port: next bucket on the read cycle, else the held bucket
    assign bkt_sel   = !use_sel ? rem_reg : (sel_ok ? BW'(sel_reg) : '0);
    assign cnt_addr  = cmd.cnt_rd ? bkt_sel : bkt_reg;
    assign cnt_wdata = cmd.cnt_inc ? cnt_reg + 1'b1 : cnt_reg - 1'b1;

    cht_ram #(.WIDTH(DW), .DEPTH(BUCKETS)) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.cnt_wr),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    // chain memory
    logic [AW-1:0]    base, addr;
    logic             we;
    logic [KEY_W-1:0] wdata, rdata;

    assign base = AW'(bkt_reg) * AW'(CHAIN_DEPTH);
    always_comb
    begin
        addr  = base + AW'(idx_reg);
        wdata = key_reg;
        we    = 1'b0;
        if (cmd.key_wr_new)
        begin
            addr = base + AW'(cnt_reg);
            we   = 1'b1;
        end
        else if (cmd.key_rd_next)
            addr = base + AW'(idx_reg) + 1'b1;
        else if (cmd.key_wr_shift)
        begin
            wdata = rdata;
            we    = 1'b1;
        end
    end

    cht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // status
    always_comb
    begin
        sts.op          = op_reg;
        sts.hash_done   = (hcnt_reg == 2'(HSTEPS));
        sts.sel_bad     = !sel_ok;
        sts.cnt_zero    = (cnt_reg == '0);
        sts.cnt_full    = (32'(cnt_reg) >= 32'(CHAIN_DEPTH));
        sts.idx_at_end  = (idx_reg == cnt_reg);
        sts.idx_at_tail = (DW'(idx_reg + 1'b1) == cnt_reg);
        sts.key_match   = (rdata == key_reg);
    end

    // result register; status latched as the walk goes, shown in the response state
    logic [ST_W-1:0] pend_st_reg;
    logic            out_valid_reg;
    logic [ST_W-1:0] status_reg;
    logic [KEY_W-1:0] key_out_reg;
    logic            last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_status != '0 || cmd.key_wr_new)
            pend_st_reg <= cmd.out_status;
        if (cmd.load)
            pend_st_reg <= ST_INSERTED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_listed)
            begin
                status_reg  <= ST_LISTED;
                key_out_reg <= rdata;
                last_reg    <= (DW'(idx_reg + 1'b1) == cnt_reg);
            end
            else
            begin
                status_reg  <= pend_st_reg;
                key_out_reg <= (pend_st_reg == ST_EMPTY) ? '0 : key_reg;
                last_reg    <= 1'b1;
            end
        end
    end

    assign out_busy  = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign key_out   = key_out_reg;
    assign last      = last_reg;

    logic unused_ok;
    assign unused_ok = cmd.out_last_auto ^ cmd.key_rd;
endmodule
`default_nettype wire

// File: verif/cht_checker.sv
// Checker for the chained hash table core: watches both channels, predicts results.
// Depends on cht_pkg.
`timescale 1ns / 100ps
module cht_checker
    import cht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [OP_W-1:0]  op,
    input  logic [KEY_W-1:0] key,
    input  logic [SEL_W-1:0] bucket,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [ST_W-1:0]  status,
    input  logic [KEY_W-1:0] key_out,
    input  logic             last,
    output int               fail_count,
    output int               pending
);
    localparam int NB    = 101;
    localparam int DEPTH = 8;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] key_out;
        logic             last;
    } hash_result_t;

    logic [KEY_W-1:0] table_keys [NB][DEPTH];
    int               table_count [NB];
    hash_result_t     expected_results [$];

    assign pending = expected_results.size();

    // apply one request to the table copy and queue its results
    task automatic apply_request(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
                                 input logic [SEL_W-1:0] sel);
        int b;
        int pos;
        int n;
        b = k % NB;
        pos = -1;
        for (int i = 0; i < table_count[b]; i++)
            if (pos < 0 && table_keys[b][i] == k) pos = i;
        case (o)
            OP_INSERT:
            begin
                if (table_count[b] >= DEPTH)
                    expected_results.push_back('{ST_FULL, k, 1'b1});
                else
                begin
                    table_keys[b][table_count[b]] = k;
                    table_count[b]++;
                    expected_results.push_back('{ST_INSERTED, k, 1'b1});
                end
            end
            OP_SEARCH:
                expected_results.push_back('{(pos >= 0) ? ST_FOUND : ST_ABSENT, k, 1'b1});
            OP_DELETE:
            begin
                if (pos < 0)
                    expected_results.push_back('{ST_ABSENT, k, 1'b1});
                else
                begin
                    n = table_count[b];
                    for (int i = pos; i + 1 < n; i++)
                        table_keys[b][i] = table_keys[b][i + 1];
                    table_count[b] = n - 1;
                    expected_results.push_back('{ST_FOUND, k, 1'b1});
                end
            end
            default:
            begin
                if (sel >= NB || table_count[sel] == 0)
                    expected_results.push_back('{ST_EMPTY, '0, 1'b1});
                else
                    for (int i = 0; i < table_count[sel]; i++)
                        expected_results.push_back('{ST_LISTED, table_keys[sel][i],
                                                     i + 1 == table_count[sel]});
            end
        endcase
    endtask

    initial
    begin
        fail_count = 0;
        for (int i = 0; i < NB; i++) table_count[i] = 0;
    end

    // sample both channels at the edge
    always @(posedge clk)
    begin
        hash_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d key_out %0d last %0d",
                           status, key_out, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (key_out !== want.key_out)
                    begin
                        $error("key_out: expected %0d, actual %0d", want.key_out, key_out);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                apply_request(op, key, bucket);
        end
    end
endmodule

// File: verif/tb_top.sv
// Testbench top for chained_hash_table_core: clock, reset, request stimulus, verdict.
// Depends on cht_pkg, cht_checker and the core.
`timescale 1ns / 100ps
module tb_top
    import cht_pkg::*;
();
    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [SEL_W-1:0] bucket;
    logic             out_valid;
    logic             out_ready;
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] key_out;
    logic             last;
    int               fail_count;
    int               pending;
    int               recv_stall_pct;
    int               send_idle_pct;

    chained_hash_table_core dut (.*);

    cht_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // one request; optional idle gap first
    task automatic send_request(input logic [OP_W-1:0] o, input logic [KEY_W-1:0] k,
                                input logic [SEL_W-1:0] sel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        key      <= k;
        bucket   <= sel;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // keys that land in a handful of buckets so chains fill up
    function automatic logic [KEY_W-1:0] hot_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom_range(3) + 101 * $urandom_range(21262142));
        if ($urandom_range(9) == 0) k = KEY_W'({$urandom} >> 1);
        return k;
    endfunction

    task automatic random_phase(input int count);
        logic [OP_W-1:0] o;
        for (int i = 0; i < count; i++)
        begin
            o = OP_W'($urandom_range(3));
            if (o == OP_DISPLAY)
                send_request(o, KEY_W'({$urandom} >> 1),
                             ($urandom_range(4) == 0) ? SEL_W'($urandom)
                                                      : SEL_W'($urandom_range(4)));
            else
                send_request(o, hot_key(), SEL_W'($urandom));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_INSERT;
        key = '0;
        bucket = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, full chain, extremes, out-of-range bucket
        send_request(OP_DISPLAY, '0, 7'd0);
        send_request(OP_SEARCH, '1, '0);
        send_request(OP_DELETE, '0, '0);
        for (int i = 0; i < 9; i++)
            send_request(OP_INSERT, KEY_W'(7 + 101 * i), '1);
        send_request(OP_DISPLAY, '0, 7'd7);
        send_request(OP_INSERT, '1, '0);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, 31'd7, '0);
        send_request(OP_SEARCH, 31'd209, '0);
        send_request(OP_DELETE, 31'd209, '0);
        send_request(OP_DISPLAY, '0, 7'd7);
        send_request(OP_DISPLAY, '0, 7'd100);
        send_request(OP_DISPLAY, '0, 7'd101);
        send_request(OP_DISPLAY, '0, '1);
        send_request(OP_SEARCH, '1, '0);
        send_request(OP_DELETE, '1, '0);
        send_request(OP_DISPLAY, '1, 7'd0);
        // hold off until everything is back
        drain();

        send_idle_pct = 8;
        recv_stall_pct = 45;
        random_phase(60);
        send_idle_pct = 45;
        recv_stall_pct = 8;
        random_phase(60);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(60);
        drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("PASS chained_hash_table_core");
        else
            $display("FAIL chained_hash_table_core");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL chained_hash_table_core");
        $finish;
    end
endmodule

// File: chained_hash_table_core.f
+incdir+design
design/cht_pkg.sv
design/cht_ram.sv
design/cht_ctrl.sv
design/cht_dp.sv
design/chained_hash_table_core.sv
verif/cht_checker.sv
verif/tb_top.sv
